[hw/rtl/slx_pkg.sv]
package slx_pkg;

  localparam int FIELD_W = 20;
  localparam int KIND_W  = 5;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Lexer modes: which multi-byte token is still open.
  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_NUMBER,
    M_STRING,
    M_COMMENT,
    M_PLUS,
    M_SLASH,
    M_BANG,
    M_EQ1,
    M_EQ2,
    M_GT,
    M_LT,
    M_DOT1,
    M_DOT2,
    M_DOT3
  } mode_t;

  // Token kinds as seen on the result channel.
  localparam logic [KIND_W-1:0] K_IDENT  = 5'd0;
  localparam logic [KIND_W-1:0] K_NUMBER = 5'd1;
  localparam logic [KIND_W-1:0] K_LPAREN = 5'd2;
  localparam logic [KIND_W-1:0] K_RPAREN = 5'd3;
  localparam logic [KIND_W-1:0] K_LBRACE = 5'd4;
  localparam logic [KIND_W-1:0] K_RBRACE = 5'd5;
  localparam logic [KIND_W-1:0] K_STRING = 5'd6;
  localparam logic [KIND_W-1:0] K_SEMI   = 5'd7;
  localparam logic [KIND_W-1:0] K_COMMA  = 5'd8;
  localparam logic [KIND_W-1:0] K_PLUS   = 5'd9;
  localparam logic [KIND_W-1:0] K_MINUS  = 5'd10;
  localparam logic [KIND_W-1:0] K_STAR   = 5'd11;
  localparam logic [KIND_W-1:0] K_SLASH  = 5'd12;
  localparam logic [KIND_W-1:0] K_COLON  = 5'd13;
  localparam logic [KIND_W-1:0] K_NOT    = 5'd14;
  localparam logic [KIND_W-1:0] K_NE     = 5'd15;
  localparam logic [KIND_W-1:0] K_EQ     = 5'd16;
  localparam logic [KIND_W-1:0] K_EQEQ   = 5'd17;
  localparam logic [KIND_W-1:0] K_GT     = 5'd18;
  localparam logic [KIND_W-1:0] K_LT     = 5'd19;
  localparam logic [KIND_W-1:0] K_DOT1   = 5'd20;
  localparam logic [KIND_W-1:0] K_DOT2   = 5'd21;
  localparam logic [KIND_W-1:0] K_DOT3   = 5'd22;
  localparam logic [KIND_W-1:0] K_ERROR  = 5'd23;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] line;
    logic               last;
  } token_t;

  // Front to queue: up to two tokens per byte, in order.
  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  // Queue to back: oldest waiting token.
  typedef struct packed {
    logic   valid;
    token_t tok;
  } head_t;

endpackage

[hw/rtl/slx_in_if.sv]
interface slx_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

[hw/rtl/slx_out_if.sv]
interface slx_out_if import slx_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [FIELD_W-1:0] start_offset;
  logic [FIELD_W-1:0] text_length;
  logic [FIELD_W-1:0] line_number;
  logic               last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output text_length, output line_number, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input start_offset,
                input text_length, input line_number, input last_of_run,
                output ready);
endinterface

[hw/rtl/slx_front.sv]
module slx_front import slx_pkg::*; #(
  parameter int POSITION_BITS = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  slx_in_if.sink       in_ch,
  input  logic         q_room,
  output push_t        push
);

  localparam int PB = POSITION_BITS;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
  localparam logic [PB-1:0] ONE     = {{(PB-1){1'b0}}, 1'b1};

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  mode_t         mode_r, mode_nxt;
  logic [PB-1:0] tstart_r, tstart_nxt;
  logic [PB-1:0] tlen_r, tlen_nxt;
  logic [PB-1:0] tline_r, tline_nxt;
  logic [PB-1:0] cline_r, cline_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic          halted_r, halted_nxt;

  logic   accept;
  logic   took;
  logic   err;
  logic   e1v, e2v, e3v;
  token_t e1, e2, e3;
  token_t slot0, slot1;
  logic   s0v, s1v;

  function automatic token_t mk(logic [KIND_W-1:0] k, logic [PB-1:0] s,
                                logic [PB-1:0] l, logic [PB-1:0] ln);
    token_t t;
    t.kind  = k;
    t.start = FIELD_W'(s);
    t.len   = FIELD_W'(l);
    t.line  = FIELD_W'(ln);
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic logic [KIND_W-1:0] mode_kind(mode_t m);
    logic [KIND_W-1:0] k;
    case (m)
      M_IDENT:  k = K_IDENT;
      M_NUMBER: k = K_NUMBER;
      M_STRING: k = K_STRING;
      M_PLUS:   k = K_PLUS;
      M_SLASH:  k = K_SLASH;
      M_BANG:   k = K_NOT;
      M_EQ1:    k = K_EQ;
      M_EQ2:    k = K_EQEQ;
      M_GT:     k = K_GT;
      M_LT:     k = K_LT;
      M_DOT1:   k = K_DOT1;
      M_DOT2:   k = K_DOT2;
      M_DOT3:   k = K_DOT3;
      default:  k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [PB-1:0] grow(logic [PB-1:0] l);
    return (l == POS_MAX) ? l : l + ONE;
  endfunction

  assign accept      = in_ch.valid && q_room;
  assign in_ch.ready = q_room;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_ch.end_of_text)) begin
      mode_r   <= M_IDLE;
      tstart_r <= '0;
      tlen_r   <= '0;
      tline_r  <= ONE;
      cline_r  <= ONE;
      pos_r    <= '0;
      prev_r   <= '0;
      halted_r <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      tline_r  <= tline_nxt;
      cline_r  <= cline_nxt;
      pos_r    <= pos_nxt;
      prev_r   <= prev_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    tline_nxt  = tline_r;
    cline_nxt  = cline_r;
    pos_nxt    = pos_r;
    prev_nxt   = prev_r;
    halted_nxt = halted_r;
    took = 1'b0;
    err  = 1'b0;
    e1v  = 1'b0;
    e2v  = 1'b0;
    e3v  = 1'b0;
    e1   = '0;
    e2   = '0;
    e3   = '0;

    if (!halted_r) begin
      // Continue the open token, or close it.
      mode_nxt = M_IDLE;
      case (mode_r)
        M_IDENT, M_NUMBER: begin
          if (is_digit(in_ch.text_byte) || (mode_r == M_IDENT &&
              (is_letter(in_ch.text_byte) || in_ch.text_byte == CH_UNDER))) begin
            mode_nxt = mode_r;
            tlen_nxt = grow(tlen_r);
            took     = 1'b1;
          end else begin
            e1v = 1'b1;
            e1  = mk(mode_kind(mode_r), tstart_r, tlen_r, tline_r);
          end
        end
        M_STRING: begin
          took = 1'b1;
          if (in_ch.text_byte == CH_QUOTE && prev_r != CH_BSLASH) begin
            e1v = 1'b1;
            e1  = mk(K_STRING, tstart_r, tlen_r, tline_r);
          end else begin
            mode_nxt = M_STRING;
            tlen_nxt = grow(tlen_r);
          end
        end
        M_COMMENT: begin
          if (in_ch.text_byte != CH_NL) begin
            mode_nxt = M_COMMENT;
            took     = 1'b1;
          end
        end
        M_SLASH: begin
          if (in_ch.text_byte == CH_SLASH) begin
            mode_nxt = M_COMMENT;
            took     = 1'b1;
          end else begin
            e1v = 1'b1;
            e1  = mk(K_SLASH, tstart_r, tlen_r, tline_r);
          end
        end
        M_BANG: begin
          e1v = 1'b1;
          if (in_ch.text_byte == CH_EQ) begin
            took = 1'b1;
            e1   = mk(K_NE, tstart_r, tlen_r, tline_r);
          end else begin
            e1   = mk(K_NOT, tstart_r, tlen_r, tline_r);
          end
        end
        M_EQ1, M_DOT1, M_DOT2: begin
          if ((mode_r == M_EQ1 && in_ch.text_byte == CH_EQ) ||
              (mode_r != M_EQ1 && in_ch.text_byte == CH_DOT)) begin
            mode_nxt = (mode_r == M_EQ1) ? M_EQ2 : (mode_r == M_DOT1) ? M_DOT2 : M_DOT3;
            took     = 1'b1;
          end else begin
            e1v = 1'b1;
            e1  = mk(mode_kind(mode_r), tstart_r, tlen_r, tline_r);
          end
        end
        M_PLUS, M_EQ2, M_GT, M_LT, M_DOT3: begin
          // The byte that would extend these is an error.
          e1v = 1'b1;
          if ((mode_r == M_PLUS && in_ch.text_byte == CH_PLUS) ||
              (mode_r == M_DOT3 && in_ch.text_byte == CH_DOT) ||
              ((mode_r == M_EQ2 || mode_r == M_GT || mode_r == M_LT) &&
               in_ch.text_byte == CH_EQ)) begin
            took       = 1'b1;
            err        = 1'b1;
            halted_nxt = 1'b1;
            e1         = mk(K_ERROR, pos_r, '0, cline_r);
          end else begin
            e1 = mk(mode_kind(mode_r), tstart_r, tlen_r, tline_r);
          end
        end
        default: begin
        end
      endcase

      // Start a new token on a byte that nothing took.
      if (!took) begin
        if (in_ch.text_byte <= CH_SPACE || in_ch.text_byte == CH_DEL) begin
          if (in_ch.text_byte == CH_NL && cline_r != POS_MAX) begin
            cline_nxt = cline_r + ONE;
          end
        end else if (is_letter(in_ch.text_byte) || is_digit(in_ch.text_byte)) begin
          mode_nxt   = is_digit(in_ch.text_byte) ? M_NUMBER : M_IDENT;
          tstart_nxt = pos_r;
          tlen_nxt   = ONE;
          tline_nxt  = cline_r;
        end else begin
          tstart_nxt = pos_r;
          tlen_nxt   = '0;
          tline_nxt  = cline_r;
          case (in_ch.text_byte)
            CH_LPAREN: begin e2v = 1'b1; e2 = mk(K_LPAREN, pos_r, '0, cline_r); end
            CH_RPAREN: begin e2v = 1'b1; e2 = mk(K_RPAREN, pos_r, '0, cline_r); end
            CH_LBRACE: begin e2v = 1'b1; e2 = mk(K_LBRACE, pos_r, '0, cline_r); end
            CH_RBRACE: begin e2v = 1'b1; e2 = mk(K_RBRACE, pos_r, '0, cline_r); end
            CH_SEMI:   begin e2v = 1'b1; e2 = mk(K_SEMI, pos_r, '0, cline_r); end
            CH_COMMA:  begin e2v = 1'b1; e2 = mk(K_COMMA, pos_r, '0, cline_r); end
            CH_MINUS:  begin e2v = 1'b1; e2 = mk(K_MINUS, pos_r, '0, cline_r); end
            CH_STAR:   begin e2v = 1'b1; e2 = mk(K_STAR, pos_r, '0, cline_r); end
            CH_COLON:  begin e2v = 1'b1; e2 = mk(K_COLON, pos_r, '0, cline_r); end
            CH_QUOTE: begin
              mode_nxt   = M_STRING;
              tstart_nxt = pos_r + ONE;
            end
            CH_PLUS:  mode_nxt = M_PLUS;
            CH_SLASH: mode_nxt = M_SLASH;
            CH_BANG:  mode_nxt = M_BANG;
            CH_EQ:    mode_nxt = M_EQ1;
            CH_GT:    mode_nxt = M_GT;
            CH_LT:    mode_nxt = M_LT;
            CH_DOT:   mode_nxt = M_DOT1;
            default: begin
              // Unknown byte: report and halt.
              tstart_nxt = tstart_r;
              tlen_nxt   = tlen_r;
              tline_nxt  = tline_r;
              err        = 1'b1;
              halted_nxt = 1'b1;
              e2v        = 1'b1;
              e2         = mk(K_ERROR, pos_r, '0, cline_r);
            end
          endcase
        end
      end

      prev_nxt = in_ch.text_byte;
      pos_nxt  = pos_r + ONE;

      // Flush whatever is still open on the final byte.
      if (in_ch.end_of_text && !err) begin
        case (mode_nxt)
          M_IDLE, M_COMMENT: begin
          end
          M_STRING: begin
            e3v = 1'b1;
            e3  = mk(K_ERROR, pos_r, '0, cline_nxt);
          end
          default: begin
            e3v = 1'b1;
            e3  = mk(mode_kind(mode_nxt), tstart_nxt, tlen_nxt, tline_nxt);
          end
        endcase
      end
    end

    // Pack the first two candidates in order and mark the last one.
    s0v   = e1v || e2v || e3v;
    slot0 = e1v ? e1 : (e2v ? e2 : e3);
    s1v   = e1v ? (e2v || e3v) : (e2v && e3v);
    slot1 = (e1v && e2v) ? e2 : e3;
    if (s1v) begin
      slot1.last = 1'b1;
    end else begin
      slot0.last = 1'b1;
    end

    push.tok0 = slot0;
    push.tok1 = slot1;
    push.cnt  = accept ? {s1v, s0v && !s1v} : 2'd0;
  end

endmodule

[hw/rtl/slx_queue.sv]
module slx_queue import slx_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output head_t head,
  output logic  room
);

  localparam logic [Q_AW:0] ROOM_MAX = (Q_AW+1)'(Q_DEPTH - 2);

  token_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, wr_nxt;
  logic [Q_AW-1:0] rd_r, rd_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  assign room       = count_r <= ROOM_MAX;
  assign head.valid = count_r != '0;
  assign head.tok   = mem_r[rd_r];

  always_comb begin
    wr_nxt    = wr_r + Q_AW'(push.cnt);
    rd_nxt    = pop ? rd_r + 1'b1 : rd_r;
    count_nxt = count_r + (Q_AW+1)'(push.cnt) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_r] <= push.tok0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_r + 1'b1] <= push.tok1;
    end
  end

endmodule

[hw/rtl/slx_back.sv]
module slx_back import slx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  head_t      head,
  output logic       pop,
  slx_out_if.source  out_ch
);

  logic   out_valid_r, out_valid_nxt;
  token_t out_tok_r;

  // Refill the output register whenever it is empty or being drained.
  assign pop           = head.valid && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = pop || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_tok_r <= head.tok;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_kind   = out_tok_r.kind;
  assign out_ch.start_offset = out_tok_r.start;
  assign out_ch.text_length  = out_tok_r.len;
  assign out_ch.line_number  = out_tok_r.line;
  assign out_ch.last_of_run  = out_tok_r.last;

endmodule

[hw/rtl/source_text_lexer.sv]
// Channel  Dir  Payload                                               Accepted when
// in_ch    in   text_byte[7:0], end_of_text                           valid && ready
// out_ch   out  token_kind[4:0], start_offset[19:0], text_length[19:0],
//               line_number[19:0], last_of_run                        valid && ready
//
// One byte is taken per cycle while the token queue has two free entries; a byte
// yields up to two tokens, and the output register drains one token per cycle while
// out_ch.ready is high. A token reaches out_ch through the queue and the output register.
// rst_n is synchronous: it clears the lexer mode, counters and queue pointers.
// A stalled out_ch holds its token; the 4-entry queue absorbs the backlog and
// in_ch.ready drops once fewer than two entries are free.
module source_text_lexer import slx_pkg::*; #(
  parameter int POSITION_BITS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  slx_in_if.sink     in_ch,
  slx_out_if.source  out_ch
);

  push_t push;
  head_t head;
  logic  q_room;
  logic  pop;

  // Front: classify each request byte, track the open token and line count,
  // and push the tokens it closes in order.
  slx_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_room (q_room),
    .push   (push)
  );

  // Queue: decouple the byte stream from the token stream.
  slx_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .room  (q_room)
  );

  // Back: hold each token in the output register until it is taken.
  slx_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

[tb/tb_source_text_lexer.sv]
`timescale 1ns / 1ps

module tb_source_text_lexer;
  import slx_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [FIELD_W-1:0] POS_MAX = '1;

  // Bytes with a role of their own in the lexer.
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_BSLASH     = 8'h5C;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_NL         = 8'h0A;

  logic clk = 1'b0;
  logic rst_n;

  slx_in_if  in_ch ();
  slx_out_if out_ch ();

  source_text_lexer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Lexer predictor: its own copy of the mode, the pending token and the
  // position counters, advanced once per accepted request.
  // ---------------------------------------------------------------------------
  mode_t              lx_mode;
  logic [FIELD_W-1:0] lx_tok_start;
  logic [FIELD_W-1:0] lx_tok_len;
  logic [FIELD_W-1:0] lx_tok_line;
  logic [FIELD_W-1:0] lx_line;
  logic [FIELD_W-1:0] lx_pos;
  logic [7:0]         lx_prev;
  bit                 lx_halted;

  token_t run_toks [2];   // tokens caused by the byte being lexed
  int     run_n;
  token_t expected_tokens [$];

  int mismatches = 0;
  int bytes_sent = 0;
  int cycle_count;

  int unsigned max_in_gap  = 6;
  int unsigned max_out_gap = 6;

  logic [7:0] text_buf [$];

  function void lexer_reset();
    lx_mode      = M_IDLE;
    lx_tok_start = '0;
    lx_tok_len   = '0;
    lx_tok_line  = 1;
    lx_line      = 1;
    lx_pos       = '0;
    lx_prev      = '0;
    lx_halted    = 1'b0;
  endfunction

  function bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // A byte yields at most two tokens; drop anything beyond that.
  function void emit_token(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] start,
                           logic [FIELD_W-1:0] len, logic [FIELD_W-1:0] line);
    token_t t;
    if (run_n >= 2) return;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.last  = 1'b0;
    run_toks[run_n] = t;
    run_n++;
  endfunction

  function void emit_pending(logic [KIND_W-1:0] kind);
    emit_token(kind, lx_tok_start, lx_tok_len, lx_tok_line);
  endfunction

  // Report the error where it was seen, then ignore bytes up to end of text.
  function void raise_error(logic [FIELD_W-1:0] pos);
    emit_token(K_ERROR, pos, '0, lx_line);
    lx_halted = 1'b1;
    lx_mode   = M_IDLE;
  endfunction

  function void open_pending(mode_t m, logic [FIELD_W-1:0] start,
                             logic [FIELD_W-1:0] len);
    lx_mode      = m;
    lx_tok_start = start;
    lx_tok_len   = len;
    lx_tok_line  = lx_line;
  endfunction

  function void grow_token();
    if (lx_tok_len != POS_MAX) lx_tok_len++;
  endfunction

  // Offer the byte to the open token; 1 means the token consumed it.
  function bit continue_token(logic [7:0] c, logic [FIELD_W-1:0] pos);
    mode_t m;
    m = lx_mode;
    lx_mode = M_IDLE;
    case (m)
      M_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE) begin
          lx_mode = m;
          grow_token();
          return 1'b1;
        end
        emit_pending(K_IDENT);
      end
      M_NUMBER: begin
        if (is_digit(c)) begin
          lx_mode = m;
          grow_token();
          return 1'b1;
        end
        emit_pending(K_NUMBER);
      end
      M_STRING: begin
        // An escaped quote is only the byte right after a backslash.
        if (c == CH_QUOTE && lx_prev != CH_BSLASH) begin
          emit_pending(K_STRING);
          return 1'b1;
        end
        lx_mode = m;
        grow_token();
        return 1'b1;
      end
      M_COMMENT: begin
        // Hand the newline back so that it is counted as whitespace.
        if (c == CH_NL) return 1'b0;
        lx_mode = m;
        return 1'b1;
      end
      M_PLUS: begin
        if (c == "+") begin
          raise_error(pos);
          return 1'b1;
        end
        emit_pending(K_PLUS);
      end
      M_SLASH: begin
        if (c == CH_SLASH) begin
          lx_mode = M_COMMENT;
          return 1'b1;
        end
        emit_pending(K_SLASH);
      end
      M_BANG: begin
        if (c == "=") begin
          emit_pending(K_NE);
          return 1'b1;
        end
        emit_pending(K_NOT);
      end
      M_EQ1: begin
        if (c == "=") begin
          lx_mode = M_EQ2;
          return 1'b1;
        end
        emit_pending(K_EQ);
      end
      M_EQ2: begin
        if (c == "=") begin
          raise_error(pos);
          return 1'b1;
        end
        emit_pending(K_EQEQ);
      end
      M_GT, M_LT: begin
        if (c == "=") begin
          raise_error(pos);
          return 1'b1;
        end
        emit_pending(m == M_GT ? K_GT : K_LT);
      end
      M_DOT1, M_DOT2: begin
        if (c == ".") begin
          lx_mode = (m == M_DOT1) ? M_DOT2 : M_DOT3;
          return 1'b1;
        end
        emit_pending(m == M_DOT1 ? K_DOT1 : K_DOT2);
      end
      M_DOT3: begin
        if (c == ".") begin
          raise_error(pos);
          return 1'b1;
        end
        emit_pending(K_DOT3);
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function void start_token(logic [7:0] c, logic [FIELD_W-1:0] pos);
    if (c <= 8'd32 || c == 8'd127) begin
      if (c == CH_NL && lx_line != POS_MAX) lx_line++;
      return;
    end
    if (is_letter(c)) begin
      open_pending(M_IDENT, pos, 1);
      return;
    end
    if (is_digit(c)) begin
      open_pending(M_NUMBER, pos, 1);
      return;
    end
    case (c)
      "(":       emit_token(K_LPAREN, pos, '0, lx_line);
      ")":       emit_token(K_RPAREN, pos, '0, lx_line);
      "{":       emit_token(K_LBRACE, pos, '0, lx_line);
      "}":       emit_token(K_RBRACE, pos, '0, lx_line);
      ";":       emit_token(K_SEMI, pos, '0, lx_line);
      ",":       emit_token(K_COMMA, pos, '0, lx_line);
      "-":       emit_token(K_MINUS, pos, '0, lx_line);
      "*":       emit_token(K_STAR, pos, '0, lx_line);
      ":":       emit_token(K_COLON, pos, '0, lx_line);
      CH_QUOTE:  open_pending(M_STRING, pos + 1'b1, '0);
      "+":       open_pending(M_PLUS, pos, '0);
      CH_SLASH:  open_pending(M_SLASH, pos, '0);
      "!":       open_pending(M_BANG, pos, '0);
      "=":       open_pending(M_EQ1, pos, '0);
      ">":       open_pending(M_GT, pos, '0);
      "<":       open_pending(M_LT, pos, '0);
      ".":       open_pending(M_DOT1, pos, '0);
      default:   raise_error(pos);
    endcase
  endfunction

  // End of text: close whatever token is still open.
  function void flush_token(logic [FIELD_W-1:0] pos);
    case (lx_mode)
      M_IDENT:  emit_pending(K_IDENT);
      M_NUMBER: emit_pending(K_NUMBER);
      M_STRING: raise_error(pos);
      M_PLUS:   emit_pending(K_PLUS);
      M_SLASH:  emit_pending(K_SLASH);
      M_BANG:   emit_pending(K_NOT);
      M_EQ1:    emit_pending(K_EQ);
      M_EQ2:    emit_pending(K_EQEQ);
      M_GT:     emit_pending(K_GT);
      M_LT:     emit_pending(K_LT);
      M_DOT1:   emit_pending(K_DOT1);
      M_DOT2:   emit_pending(K_DOT2);
      M_DOT3:   emit_pending(K_DOT3);
      default:  ;
    endcase
  endfunction

  function void lex_byte(logic [7:0] c, logic eot);
    logic [FIELD_W-1:0] pos;
    bit                 taken;
    pos   = lx_pos;
    run_n = 0;
    if (!lx_halted) begin
      taken = continue_token(c, pos);
      if (!taken && !lx_halted) start_token(c, pos);
      lx_prev = c;
      lx_pos  = pos + 1'b1;
      if (eot && !lx_halted) flush_token(pos);
    end
    if (run_n > 0) run_toks[run_n - 1].last = 1'b1;
    for (int k = 0; k < run_n; k++) expected_tokens.push_back(run_toks[k]);
    if (eot) lexer_reset();
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted request, check every accepted token.
  // Both reads happen before the edge's updates land, so the order is fixed.
  // ---------------------------------------------------------------------------
  bit out_taken = 1'b0;
  int sink_wait = 0;

  function void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : token_monitor
    token_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) lex_byte(in_ch.text_byte, in_ch.end_of_text);
      if (out_ch.valid && out_ch.ready) begin
        out_taken = 1'b1;
        if (expected_tokens.size() == 0) begin
          mismatches++;
          $display("%0t: token expected none, actual kind %0d offset %0d", $time,
                   out_ch.token_kind, out_ch.start_offset);
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", want.kind, out_ch.token_kind);
          check_field("start_offset", want.start, out_ch.start_offset);
          check_field("text_length", want.len, out_ch.text_length);
          check_field("line_number", want.line, out_ch.line_number);
          check_field("last_of_run", want.last, out_ch.last_of_run);
        end
      end
    end
  end

  // Token sink: after each taken token, drop ready for a random stretch.
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      sink_wait = $urandom_range(0, max_out_gap);
    end
    if (sink_wait > 0) begin
      out_ch.ready = 1'b0;
      sink_wait--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------

  // Idle a random number of cycles, then hold the request until it is taken.
  task automatic send_text_byte(input logic [7:0] b, input logic eot);
    int unsigned gap;
    gap = $urandom_range(0, max_in_gap);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.text_byte   = b;
    in_ch.end_of_text = eot;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Send the buffered text; its final byte carries end_of_text.
  task automatic send_text();
    foreach (text_buf[i]) send_text_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  function void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  function void add_separator(int unsigned lo, int unsigned hi);
    repeat ($urandom_range(lo, hi)) begin
      case ($urandom_range(0, 6))
        0:       text_buf.push_back(" ");
        1:       text_buf.push_back(8'h09);
        2, 3:    text_buf.push_back(CH_NL);
        4:       text_buf.push_back(8'h00);
        5:       text_buf.push_back(8'd127);
        default: text_buf.push_back(8'($urandom_range(0, 32)));
      endcase
    end
  endfunction

  // String body: printable and high bytes but no bare quote; escaped quotes, lone backslashes and newlines too.
  function void add_string_body();
    logic [7:0] b;
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 6))
        0: begin
          text_buf.push_back(CH_BSLASH);
          text_buf.push_back(CH_QUOTE);
        end
        1:       text_buf.push_back(CH_NL);
        2:       text_buf.push_back(CH_BSLASH);
        3:       text_buf.push_back(8'($urandom_range(128, 255)));
        default: begin
          b = 8'($urandom_range(32, 126));
          text_buf.push_back(b == CH_QUOTE ? rand_letter() : b);
        end
      endcase
    end
    // keep the closing quote from being escaped
    if (text_buf.size() != 0 && text_buf[text_buf.size() - 1] == CH_BSLASH)
      text_buf.push_back("x");
  endfunction

  // Append one well-formed token; 1 asks for whitespace after it so that
  // operators do not run into the next token.
  function bit add_word_piece();
    logic [7:0] b;
    case ($urandom_range(0, 8))
      0, 1: begin
        text_buf.push_back(rand_letter());
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 2))
            0:       text_buf.push_back(rand_letter());
            1:       text_buf.push_back(8'($urandom_range(48, 57)));
            default: text_buf.push_back(CH_UNDERSCORE);
          endcase
        end
      end
      2: repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(48, 57)));
      3: begin
        text_buf.push_back(CH_QUOTE);
        add_string_body();
        text_buf.push_back(CH_QUOTE);
      end
      4, 5: begin
        case ($urandom_range(0, 8))
          0:       add_str("(");
          1:       add_str(")");
          2:       add_str("{");
          3:       add_str("}");
          4:       add_str(";");
          5:       add_str(",");
          6:       add_str("-");
          7:       add_str("*");
          default: add_str(":");
        endcase
      end
      6, 7: begin
        case ($urandom_range(0, 10))
          0:       add_str("+");
          1:       add_str("/");
          2:       add_str("!");
          3:       add_str("!=");
          4:       add_str("=");
          5:       add_str("==");
          6:       add_str(">");
          7:       add_str("<");
          8:       add_str(".");
          9:       add_str("..");
          default: add_str("...");
        endcase
        return 1'b1;
      end
      default: begin
        add_str("//");
        repeat ($urandom_range(0, 8)) begin
          b = 8'($urandom_range(0, 255));
          text_buf.push_back(b == CH_NL ? "c" : b);
        end
        text_buf.push_back(CH_NL);
      end
    endcase
    return 1'b0;
  endfunction

  function void add_broken_piece();
    string odd;
    odd = "#$%&'?@[]^`|~";
    case ($urandom_range(0, 7))
      0: add_str("++");
      1: add_str(">=");
      2: add_str("<=");
      3: add_str("===");
      4: add_str("....");
      5: begin
        // an identifier may not open with an underscore
        text_buf.push_back(CH_UNDERSCORE);
        text_buf.push_back(rand_letter());
      end
      6: text_buf.push_back(odd[$urandom_range(0, odd.len() - 1)]);
      default: text_buf.push_back(8'($urandom_range(128, 255)));
    endcase
  endfunction

  // Build one text of tokens and whitespace; optionally plant one error and
  // optionally leave a string open at the end.
  function void build_text(int pieces, bit broken, bit open_tail);
    int err_at;
    bit spaced;
    text_buf.delete();
    err_at = broken ? $urandom_range(0, pieces - 1) : -1;
    for (int i = 0; i < pieces; i++) begin
      if (i == err_at) begin
        add_broken_piece();
        spaced = 1'b1;
      end else begin
        spaced = add_word_piece();
      end
      add_separator(spaced ? 1 : 0, 2);
    end
    if (open_tail) begin
      text_buf.push_back(CH_QUOTE);
      add_string_body();
    end
  endfunction

  function void build_noise();
    text_buf.delete();
    repeat ($urandom_range(1, 16)) text_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Identifier with underscore and digit, a NUL, a string with an escaped
  // quote, '!=', '...', a comment up to a newline and a number flushed by end
  // of text; then '++' with a byte ignored after it; then an unclosed string.
  task automatic test_directed_tokens();
    text_buf.delete();
    add_str("Az_9");
    text_buf.push_back(8'h00);
    add_str("\"\\\"\"!=...//x");
    text_buf.push_back(CH_NL);
    add_str("7");
    send_text();
    text_buf.delete();
    add_str("++");
    text_buf.push_back(8'hFF);
    send_text();
    text_buf.delete();
    add_str("\"q");
    send_text();
  endtask

  task automatic test_token_texts(int until_bytes);
    while (bytes_sent < until_bytes) begin
      build_text($urandom_range(1, 12), $urandom_range(0, 9) == 0, 1'b0);
      send_text();
    end
  endtask

  // Both sides at full rate: the queue and the ready back-pressure get no rest.
  task automatic test_back_to_back(int until_bytes);
    max_in_gap  = 0;
    max_out_gap = 0;
    test_token_texts(until_bytes);
    max_in_gap  = 6;
    max_out_gap = 6;
  endtask

  task automatic test_errors_and_noise(int until_bytes);
    while (bytes_sent < until_bytes) begin
      case ($urandom_range(0, 3))
        0, 1: build_text($urandom_range(1, 10), 1'b1, 1'b0);
        2:    build_noise();
        default: build_text($urandom_range(0, 6), 1'b0, 1'b1);
      endcase
      send_text();
    end
  endtask

  // Stretch with a fast source and a slow sink to fill the token queue.
  task automatic test_slow_sink(int until_bytes);
    max_in_gap = 0;
    test_token_texts(until_bytes);
    max_in_gap = 6;
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
    lexer_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_tokens();
    test_token_texts(650);
    test_back_to_back(900);
    test_slow_sink(1050);
    test_errors_and_noise(1450);

    in_ch.valid = 1'b0;
    // Drain: every text ended with end_of_text, so nothing stays pending.
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far above the slowest correct run.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
